@@ sv/vkpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vkpt_pkg;

   // data word and product widths
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 42;   // sign + 41-bit clamped magnitude
   localparam int SUM_W         = 44;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [40:0] MAG_LIMIT = 41'h100_0000_0000;
   localparam logic [31:0] Q_MAX     = 32'hFFFF_FFFF;

   localparam logic MODE_LOVE     = 1'b0;
   localparam logic MODE_RAYLEIGH = 1'b1;

   // side data that rides along the divide and square root lanes
   typedef struct packed {
      logic               valid;
      logic               mode;
      logic               last;
      logic [31:0]        rho;
      logic signed [31:0] k0;
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] k3;
      logic signed [31:0] k4;
      logic signed [33:0] diff;   // A - 2L
   } side_type;

   // results that wait for the second multiply group
   typedef struct packed {
      logic               valid;
      logic               mode;
      logic               last;
      logic signed [31:0] rsum;
      logic signed [31:0] s4;
   } mid_type;

   // saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(32'sh7FFF_FFFF);
      lo = -SUM_W'(33'sh0_8000_0000);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   // magnitude of a signed 32-bit word
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] m;
      m = v[31] ? 32'(-v) : v;
      return m;
   endfunction

endpackage

`default_nettype wire

@@ sv/vkpt_delay.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vkpt_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [W-1:0] din,
   output logic      [W-1:0] dout
);

   logic [W-1:0] data_ff [0:DEPTH-1];

   // plain shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            data_ff[i] <= '0;
         end
      end else begin
         data_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign dout = data_ff[DEPTH-1];

endmodule

`default_nettype wire

@@ sv/vkpt_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: q = min(floor((m << FRAC_BITS) / rho), 2^32-1),
// zero when rho is zero. One quotient bit per stage.
module vkpt_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic [31:0] num,
   input  wire logic [31:0] rho,
   output logic      [31:0] quo
);

   import vkpt_pkg::*;

   localparam int STEPS = 32;

   logic [31:0] rem_ff  [0:STEPS];
   logic [31:0] nb_ff   [0:STEPS];
   logic [31:0] q_ff    [0:STEPS];
   logic [31:0] rho_ff  [0:STEPS];
   logic        sat_ff  [0:STEPS];
   logic        zero_ff [0:STEPS];
   logic [31:0] quo_ff;

   // setup: overflow and zero checks, initial remainder
   always_ff @(posedge clock) begin
      rem_ff[0]  <= 32'(num >> (32 - FRAC_BITS));
      nb_ff[0]   <= 32'(num << FRAC_BITS);
      q_ff[0]    <= '0;
      rho_ff[0]  <= rho;
      sat_ff[0]  <= 32'(num >> (32 - FRAC_BITS)) >= rho;
      zero_ff[0] <= rho == '0;
   end

   // one quotient bit per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [32:0] r2;
      logic        ge;
      assign r2 = {rem_ff[i], nb_ff[i][31]};
      assign ge = r2 >= {1'b0, rho_ff[i]};
      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= ge ? 32'(r2 - {1'b0, rho_ff[i]}) : r2[31:0];
         nb_ff[i+1]   <= {nb_ff[i][30:0], 1'b0};
         q_ff[i+1]    <= {q_ff[i][30:0], ge};
         rho_ff[i+1]  <= rho_ff[i];
         sat_ff[i+1]  <= sat_ff[i];
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   // final select
   always_ff @(posedge clock) begin
      if (zero_ff[STEPS]) begin
         quo_ff <= '0;
      end else if (sat_ff[STEPS]) begin
         quo_ff <= Q_MAX;
      end else begin
         quo_ff <= q_ff[STEPS];
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

@@ sv/vkpt_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root of (q << FRAC_BITS), one root bit per stage.
module vkpt_sqrt #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic [31:0] q,
   output logic      [31:0] root
);

   localparam int SW  = 32 + FRAC_BITS;
   localparam int RW  = (SW + 1) / 2;
   localparam int AW2 = 2 * RW;
   localparam int RMW = RW + 2;

   logic [AW2-1:0] arg_ff  [0:RW-1];
   logic [RMW-1:0] rem_ff  [0:RW-1];
   logic [RW-1:0]  root_ff [0:RW-1];

   for (genvar i = 0; i < RW; i++) begin : g_step
      logic [AW2-1:0] arg_src;
      logic [RMW-1:0] rem_src;
      logic [RW-1:0]  root_src;
      logic [RMW+1:0] rem_t;
      logic [RMW+1:0] trial;
      logic           ge;

      if (i == 0) begin : g_first
         assign arg_src  = AW2'({q, {FRAC_BITS{1'b0}}});
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign arg_src  = arg_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      // bring in two argument bits, try (root << 2) | 1
      assign rem_t = {rem_src, arg_src[AW2-1:AW2-2]};
      assign trial = (RMW+2)'({root_src, 2'b01});
      assign ge    = rem_t >= trial;

      always_ff @(posedge clock) begin
         arg_ff[i]  <= {arg_src[AW2-3:0], 2'b00};
         rem_ff[i]  <= ge ? RMW'(rem_t - trial) : rem_t[RMW-1:0];
         root_ff[i] <= {root_src[RW-2:0], ge};
      end
   end

   assign root = 32'(root_ff[RW-1]);

endmodule

`default_nettype wire

@@ sv/vkpt_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point product of magnitudes: (a * b) >> FRAC_BITS, clamped to 2^40,
// sign applied. Two partial products, then sum and clamp.
module vkpt_mul #(
   parameter int AW        = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic [AW-1:0]                     a_mag,
   input  wire logic [31:0]                       b_mag,
   input  wire logic                              neg,
   output logic signed [vkpt_pkg::PROD_W-1:0]     prod
);

   import vkpt_pkg::*;

   localparam int H  = (AW + 1) / 2;
   localparam int HI = AW - H;
   localparam int FW = AW + 32;

   logic [H+31:0]          lo_ff;
   logic [HI+31:0]         hi_ff;
   logic                   neg_ff;
   logic [FW-1:0]          full;
   logic [FW-1:0]          sh;
   logic [40:0]            mag;
   logic signed [PROD_W-1:0] prod_ff;

   // partial products
   always_ff @(posedge clock) begin
      lo_ff  <= (H+32)'(a_mag[H-1:0] * b_mag);
      hi_ff  <= (HI+32)'(a_mag[AW-1:H] * b_mag);
      neg_ff <= neg;
   end

   // combine, scale, clamp
   always_comb begin
      full = (FW'(hi_ff) << H) + FW'(lo_ff);
      sh   = full >> FRAC_BITS;
      mag  = (sh > FW'(MAG_LIMIT)) ? MAG_LIMIT : sh[40:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ sv/vti_kernel_parameter_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none

// VTI kernel parameter transform.
// One model point per transaction: start with the req_ fields; busy is always
// low, so a point can be issued every cycle. Each point gives one result on
// the rsp_ ports, marked by rsp_strobe for exactly one cycle; the receiver
// cannot stall, and results come out in issue order.
// csr_we/csr_wdata write wave_mode (0 Love, 1 Rayleigh); the mode is sampled
// with each point, so change it only while no point is in flight.
// A point passes through the input capture registers, the divider (a setup
// register, 32 stages with one quotient bit per stage, a final select), the
// square root pipeline (one root bit per stage), two multiply groups of two
// stages and the output register.
// Throughput: one point per cycle.
// Reset clears the valid bits of the pipeline and sets wave_mode to Love;
// points in flight at reset are dropped.
module vti_kernel_parameter_transform #(
   parameter int FRAC_BITS = vkpt_pkg::FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_modulus_a,
   input  wire logic [31:0] req_modulus_c,
   input  wire logic [31:0] req_modulus_l,
   input  wire logic signed [31:0] req_modulus_f,
   input  wire logic [31:0] req_modulus_n,
   input  wire logic [31:0] req_density,
   input  wire logic signed [31:0] req_kernel_slot0,
   input  wire logic signed [31:0] req_kernel_slot1,
   input  wire logic signed [31:0] req_kernel_slot2,
   input  wire logic signed [31:0] req_kernel_slot3,
   input  wire logic signed [31:0] req_kernel_slot4,
   input  wire logic        req_last_point,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,
   output logic             rsp_strobe,
   output logic signed [31:0] rsp_result_slot0,
   output logic signed [31:0] rsp_result_slot1,
   output logic signed [31:0] rsp_result_slot2,
   output logic signed [31:0] rsp_result_slot3,
   output logic signed [31:0] rsp_result_slot4,
   output logic             rsp_result_last
);

   import vkpt_pkg::*;

   localparam int RW        = (32 + FRAC_BITS + 1) / 2;
   localparam int DIV_LAT   = 34;
   localparam int SIDE_LAT  = DIV_LAT + RW;
   localparam int MUL_LAT   = 2;

   logic        mode_ff;
   logic        in_valid_ff;
   logic        in_mode_ff;
   logic        in_last_ff;
   logic [31:0] in_a_ff, in_c_ff, in_l_ff, in_n_ff, in_rho_ff;
   logic signed [31:0] in_k0_ff, in_k1_ff, in_k2_ff, in_k3_ff, in_k4_ff;
   logic        mode_in;

   side_type side_in, side_s, side_m;
   mid_type  mid_in, mid_o;

   logic [31:0] num [0:2];
   logic [31:0] quo [0:2];
   logic [31:0] qd  [0:2];
   logic [31:0] vel [0:2];
   logic [31:0] kmag_s [0:2];
   logic        kneg_s [0:2];
   logic [31:0] kmag_m [0:2];
   logic        kneg_m [0:2];
   logic signed [PROD_W-1:0] tprod [0:2];
   logic signed [PROD_W-1:0] rprod [0:2];
   logic signed [PROD_W-1:0] uprod [0:2];
   logic signed [PROD_W-1:0] s4prod;
   logic [33:0]  dmag;
   logic signed [SUM_W-1:0] rsum;

   logic        rsp_strobe_ff;
   logic signed [31:0] slot0_ff, slot1_ff, slot2_ff, slot3_ff, slot4_ff;
   logic        last_ff;

   assign busy = 1'b0;

   // mode register
   assign mode_in = csr_we ? csr_wdata : mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LOVE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_mode_ff <= mode_ff;
      in_last_ff <= req_last_point;
      in_a_ff    <= req_modulus_a;
      in_c_ff    <= req_modulus_c;
      in_l_ff    <= req_modulus_l;
      in_n_ff    <= req_modulus_n;
      in_rho_ff  <= req_density;
      in_k0_ff   <= req_kernel_slot0;
      in_k1_ff   <= req_kernel_slot1;
      in_k2_ff   <= req_kernel_slot2;
      in_k3_ff   <= req_kernel_slot3;
      in_k4_ff   <= req_kernel_slot4;
   end

   // lane numerators: lane 0 pairs with slot 0, lane 1 with slot 1, lane 2 with L
   assign num[0] = (in_mode_ff == MODE_RAYLEIGH) ? in_a_ff : in_n_ff;
   assign num[1] = (in_mode_ff == MODE_RAYLEIGH) ? in_c_ff : in_l_ff;
   assign num[2] = in_l_ff;

   always_comb begin
      side_in.valid = in_valid_ff;
      side_in.mode  = in_mode_ff;
      side_in.last  = in_last_ff;
      side_in.rho   = in_rho_ff;
      side_in.k0    = in_k0_ff;
      side_in.k1    = in_k1_ff;
      side_in.k2    = in_k2_ff;
      side_in.k3    = in_k3_ff;
      side_in.k4    = in_k4_ff;
      side_in.diff  = $signed({2'b00, in_a_ff}) - $signed({1'b0, in_l_ff, 1'b0});
   end

   vkpt_delay #(.W($bits(side_type)), .DEPTH(SIDE_LAT)) u_side_dly (
      .clock(clock), .reset(reset), .din(side_in), .dout(side_s)
   );

   // kernel magnitudes per lane at the sqrt output
   assign kmag_s[0] = mag32(side_s.k0);
   assign kmag_s[1] = mag32(side_s.k1);
   assign kmag_s[2] = mag32(side_s.k2);
   assign kneg_s[0] = side_s.k0[31];
   assign kneg_s[1] = side_s.k1[31];
   assign kneg_s[2] = side_s.k2[31];

   assign kmag_m[0] = mag32(side_m.k0);
   assign kmag_m[1] = mag32(side_m.k1);
   assign kmag_m[2] = mag32(side_m.k2);
   assign kneg_m[0] = side_m.k0[31];
   assign kneg_m[1] = side_m.k1[31];
   assign kneg_m[2] = side_m.k2[31];

   // divide, square root and the two multiply groups per lane
   for (genvar i = 0; i < 3; i++) begin : g_lane
      vkpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock(clock), .num(num[i]), .rho(in_rho_ff), .quo(quo[i])
      );

      vkpt_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
         .clock(clock), .q(quo[i]), .root(vel[i])
      );

      vkpt_delay #(.W(32), .DEPTH(RW)) u_q_dly (
         .clock(clock), .reset(reset), .din(quo[i]), .dout(qd[i])
      );

      // rho * v
      vkpt_mul #(.AW(32), .FRAC_BITS(FRAC_BITS)) u_mul_t (
         .clock(clock), .a_mag(side_s.rho), .b_mag(vel[i]), .neg(1'b0),
         .prod(tprod[i])
      );

      // q * kernel for the density kernel
      vkpt_mul #(.AW(32), .FRAC_BITS(FRAC_BITS)) u_mul_r (
         .clock(clock), .a_mag(qd[i]), .b_mag(kmag_s[i]), .neg(kneg_s[i]),
         .prod(rprod[i])
      );

      // (rho * v) * kernel
      vkpt_mul #(.AW(41), .FRAC_BITS(FRAC_BITS)) u_mul_u (
         .clock(clock), .a_mag(tprod[i][40:0]), .b_mag(kmag_m[i]), .neg(kneg_m[i]),
         .prod(uprod[i])
      );
   end

   // eta kernel product
   assign dmag = side_s.diff[33] ? 34'(-side_s.diff) : side_s.diff;

   vkpt_mul #(.AW(34), .FRAC_BITS(FRAC_BITS)) u_mul_eta (
      .clock(clock), .a_mag(dmag), .b_mag(mag32(side_s.k3)),
      .neg(side_s.diff[33] ^ side_s.k3[31]), .prod(s4prod)
   );

   vkpt_delay #(.W($bits(side_type)), .DEPTH(MUL_LAT)) u_side_m_dly (
      .clock(clock), .reset(reset), .din(side_s), .dout(side_m)
   );

   // density kernel sum
   always_comb begin
      rsum = SUM_W'(rprod[0]) + SUM_W'(rprod[1]);
      if (side_m.mode == MODE_RAYLEIGH) begin
         rsum = rsum + SUM_W'(rprod[2]) + SUM_W'(side_m.k4);
      end else begin
         rsum = rsum + SUM_W'(side_m.k2);
      end
      mid_in.valid = side_m.valid;
      mid_in.mode  = side_m.mode;
      mid_in.last  = side_m.last;
      mid_in.rsum  = sat32(rsum);
      mid_in.s4    = sat32(SUM_W'(s4prod));
   end

   vkpt_delay #(.W($bits(mid_type)), .DEPTH(MUL_LAT)) u_mid_dly (
      .clock(clock), .reset(reset), .din(mid_in), .dout(mid_o)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= mid_o.valid;
      end
   end

   // doubled velocity kernels keep their sign through the extension
   always_ff @(posedge clock) begin
      slot0_ff <= mid_o.rsum;
      slot1_ff <= sat32(SUM_W'($signed({uprod[1], 1'b0})));
      slot2_ff <= sat32(SUM_W'($signed({uprod[0], 1'b0})));
      slot3_ff <= (mid_o.mode == MODE_RAYLEIGH) ?
                  sat32(SUM_W'($signed({uprod[2], 1'b0}))) : '0;
      slot4_ff <= (mid_o.mode == MODE_RAYLEIGH) ? mid_o.s4 : '0;
      last_ff  <= mid_o.last;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_slot0 = slot0_ff;
   assign rsp_result_slot1 = slot1_ff;
   assign rsp_result_slot2 = slot2_ff;
   assign rsp_result_slot3 = slot3_ff;
   assign rsp_result_slot4 = slot4_ff;
   assign rsp_result_last  = last_ff;

endmodule

`default_nettype wire
